[rtl/core/mirs_pkg.sv]
// ----------------------------------------------------------------------
// mirs_pkg
// Shared types, constants and Q32.32 helpers for the mu(I) stress pipe.
// ----------------------------------------------------------------------
package mirs_pkg;

  typedef struct packed {
    logic [63:0] strain_xx;
    logic [63:0] strain_yy;
    logic [63:0] strain_zz;
    logic [63:0] strain_xy;
    logic [63:0] strain_yz;
    logic [63:0] strain_xz;
    logic [63:0] pressure_old;
    logic [63:0] pressure_new;
  } in_t;

  typedef struct packed {
    logic [63:0] stress_xx;
    logic [63:0] stress_yy;
    logic [63:0] stress_zz;
    logic [63:0] stress_xy;
    logic [63:0] stress_yz;
    logic [63:0] stress_xz;
    logic [62:0] viscosity;
  } out_t;

  typedef logic [2:0] cfg_idx_t;

  typedef enum logic [2:0] {
    CFG_MU_S  = 3'd0,
    CFG_MU_D  = 3'd1,
    CFG_I0    = 3'd2,
    CFG_DIA   = 3'd3,
    CFG_RHO   = 3'd4,
    CFG_REG   = 3'd5,
    CFG_THETA = 3'd6
  } cfg_reg_t;

  localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
  localparam logic [63:0] SMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] P_TOL = 64'hFFFF_FFFF_FFFF_FE53;

  // unit latencies in cycles
  localparam int L_MUL  = 2;
  localparam int L_DIV  = 96;
  localparam int L_SQRT = 48;
  localparam int L_SDIV = 8;
  localparam int N_TERM = 20;
  localparam int N_E1   = 31;
  localparam int L_EXP  = N_TERM * (L_MUL + L_SDIV) + L_DIV + N_E1 * L_MUL;

  function automatic logic [63:0] f_mag(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] f_tosig(input logic [63:0] m, input logic neg);
    if (!neg) return (m > SMAX) ? SMAX : m;
    return (m >= SMIN) ? SMIN : (~m + 64'd1);
  endfunction

  function automatic logic [63:0] f_addu(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] f_adds(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
    return r;
  endfunction

  function automatic logic [63:0] f_subs(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
    return r;
  endfunction

  // elaboration-time helpers for the exp(-1) constant
  function automatic logic [63:0] f_div_small(input logic [63:0] x, input logic [4:0] d);
    logic [5:0]  r;
    logic [63:0] w;
    r = '0;
    w = x;
    for (int i = 0; i < 64; i++) begin
      r = {r[4:0], w[63]};
      w = {w[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        w[0] = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic logic [63:0] f_qdiv(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rs;
    logic [63:0] r;
    logic [63:0] q;
    logic        ovf;
    logic        bitin;
    r   = '0;
    q   = '0;
    ovf = 1'b0;
    for (int i = 95; i >= 0; i--) begin
      if (i >= 32) bitin = a[i-32];
      else bitin = 1'b0;
      rs = {r, bitin};
      if (rs >= {1'b0, b}) begin
        rs = rs - {1'b0, b};
        q  = {q[62:0], 1'b1};
        if (i >= 64) ovf = 1'b1;
      end else begin
        q = {q[62:0], 1'b0};
      end
      r = rs[63:0];
    end
    return ovf ? '1 : q;
  endfunction

  function automatic logic [63:0] f_exp_one();
    logic [63:0] s;
    logic [63:0] t;
    s = Q_ONE;
    t = Q_ONE;
    for (int k = 1; k <= N_TERM; k++) begin
      t = f_div_small(t, 5'(k));
      s = s + t;
    end
    return s;
  endfunction

  localparam logic [63:0] E1 = f_qdiv(Q_ONE, f_exp_one());

endpackage

[rtl/core/mirs_dly.sv]
// ----------------------------------------------------------------------
// mirs_dly
// Enabled delay line that keeps side data in step with the units.
// ----------------------------------------------------------------------
module mirs_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < D; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[D-1];

endmodule

[rtl/core/mirs_mul.sv]
// ----------------------------------------------------------------------
// mirs_mul
// Q32.32 unsigned multiply, four 32x32 partials then combine, saturating.
// ----------------------------------------------------------------------
module mirs_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] q
);

  logic [63:0] ll, lh, hl, hh;
  logic [33:0] mid;
  logic [65:0] hi;
  logic [63:0] q_next;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
      lh <= 64'(a[31:0]) * 64'(b[63:32]);
      hl <= 64'(a[63:32]) * 64'(b[31:0]);
      hh <= 64'(a[63:32]) * 64'(b[63:32]);
      q  <= q_next;
    end
  end

  always_comb begin
    mid = 34'(ll[63:32]) + 34'(lh[31:0]) + 34'(hl[31:0]);
    hi  = 66'(hh) + 66'(lh[63:32]) + 66'(hl[63:32]) + 66'(mid[33:32]);
    q_next = (|hi[65:32]) ? '1 : {hi[31:0], mid[31:0]};
  end

endmodule

[rtl/core/mirs_sdiv.sv]
// ----------------------------------------------------------------------
// mirs_sdiv
// 64-bit integer divide by a small divisor, eight quotient bits a stage.
// ----------------------------------------------------------------------
module mirs_sdiv (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  input  logic [4:0]  d,
  output logic [63:0] q
);
  import mirs_pkg::*;

  typedef struct packed {
    logic [4:0]  rem;
    logic [63:0] w;
    logic [4:0]  d;
  } sst_t;

  sst_t st [0:L_SDIV-1];

  for (genvar j = 0; j < L_SDIV; j++) begin : g_stg
    sst_t cur;
    sst_t nxt;
    logic [5:0] r6;

    if (j == 0) begin : g_in
      assign cur = '{rem: 5'd0, w: x, d: d};
    end else begin : g_mid
      assign cur = st[j-1];
    end

    always_comb begin
      nxt = cur;
      r6  = '0;
      for (int s = 0; s < 8; s++) begin
        r6    = {nxt.rem, nxt.w[63]};
        nxt.w = {nxt.w[62:0], 1'b0};
        if (r6 >= {1'b0, cur.d}) begin
          r6       = r6 - {1'b0, cur.d};
          nxt.w[0] = 1'b1;
        end
        nxt.rem = r6[4:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) st[j] <= nxt;
    end
  end

  assign q = st[L_SDIV-1].w;

endmodule

[rtl/core/mirs_div.sv]
// ----------------------------------------------------------------------
// mirs_div
// Q32.32 unsigned divide, restoring, one quotient bit a stage.
// Zero divisor or quotient overflow gives all ones.
// ----------------------------------------------------------------------
module mirs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] q
);
  import mirs_pkg::*;

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] a;
    logic [63:0] b;
    logic        ovf;
    logic        bz;
  } dst_t;

  dst_t st [0:L_DIV-1];

  for (genvar j = 0; j < L_DIV; j++) begin : g_stg
    localparam int I = L_DIV - 1 - j;
    dst_t        cur;
    dst_t        nxt;
    logic        bitin;
    logic [64:0] rs;
    logic        ge;

    if (j == 0) begin : g_in
      assign cur = '{r: '0, q: '0, a: a, b: b, ovf: 1'b0, bz: (b == '0)};
    end else begin : g_mid
      assign cur = st[j-1];
    end

    if (I >= 32) begin : g_bit
      assign bitin = cur.a[I-32];
    end else begin : g_zero
      assign bitin = 1'b0;
    end

    always_comb begin
      rs      = {cur.r, bitin};
      ge      = (rs >= {1'b0, cur.b});
      nxt     = cur;
      nxt.r   = ge ? 64'(rs - {1'b0, cur.b}) : rs[63:0];
      nxt.q   = {cur.q[62:0], ge};
      nxt.ovf = cur.ovf | (ge & (I >= 64));
    end

    always_ff @(posedge clk) begin
      if (en) st[j] <= nxt;
    end
  end

  assign q = (st[L_DIV-1].ovf || st[L_DIV-1].bz) ? '1 : st[L_DIV-1].q;

endmodule

[rtl/core/mirs_sqrt.sv]
// ----------------------------------------------------------------------
// mirs_sqrt
// floor(sqrt(x * 2^32)), digit-by-digit, one root bit a stage.
// ----------------------------------------------------------------------
module mirs_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [63:0] q
);
  import mirs_pkg::*;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] x;
  } qst_t;

  qst_t st [0:L_SQRT-1];

  for (genvar j = 0; j < L_SQRT; j++) begin : g_stg
    localparam int K = L_SQRT - 1 - j;
    qst_t        cur;
    qst_t        nxt;
    logic [1:0]  pair;
    logic [63:0] rem4;
    logic [63:0] trial;
    logic        ge;

    if (j == 0) begin : g_in
      assign cur = '{rem: '0, root: '0, x: x};
    end else begin : g_mid
      assign cur = st[j-1];
    end

    if (K >= 16) begin : g_pair
      assign pair = cur.x[2*K-32 +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem4     = {cur.rem[61:0], pair};
      trial    = {cur.root[61:0], 2'b01};
      ge       = (rem4 >= trial);
      nxt      = cur;
      nxt.rem  = ge ? (rem4 - trial) : rem4;
      nxt.root = {cur.root[62:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) st[j] <= nxt;
    end
  end

  assign q = st[L_SQRT-1].root;

endmodule

[rtl/core/mirs_exp.sv]
// ----------------------------------------------------------------------
// mirs_exp
// exp(-e) in Q32.32: Taylor series on the fraction, reciprocal, then
// one multiply by exp(-1) per integer unit. Zero when e >= 32.
// ----------------------------------------------------------------------
module mirs_exp (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] e,
  output logic [63:0] y
);
  import mirs_pkg::*;

  typedef struct packed {
    logic [31:0] f;
    logic [63:0] sum;
    logic        big;
    logic [4:0]  n;
  } xs_t;

  logic [63:0] term [0:N_TERM];
  xs_t         side [0:N_TERM];
  logic [63:0] yv   [0:N_E1];
  logic [5:0]  bn   [0:N_E1];

  assign term[0] = Q_ONE;
  assign side[0] = '{f: e[31:0], sum: Q_ONE, big: (|e[63:37]), n: e[36:32]};

  for (genvar k = 1; k <= N_TERM; k++) begin : g_term
    logic [63:0] pm;
    xs_t         sd;

    mirs_mul u_mul (.clk(clk), .en(en), .a(term[k-1]), .b({32'd0, side[k-1].f}), .q(pm));
    mirs_sdiv u_sdiv (.clk(clk), .en(en), .x(pm), .d(5'(k)), .q(term[k]));
    mirs_dly #(.W($bits(xs_t)), .D(L_MUL + L_SDIV)) u_side (
      .clk(clk), .en(en), .d(side[k-1]), .q(sd)
    );

    assign side[k] = '{f: sd.f, sum: sd.sum + term[k], big: sd.big, n: sd.n};
  end

  mirs_div u_rcp (.clk(clk), .en(en), .a(Q_ONE), .b(side[N_TERM].sum), .q(yv[0]));
  mirs_dly #(.W(6), .D(L_DIV)) u_bn (
    .clk(clk), .en(en), .d({side[N_TERM].big, side[N_TERM].n}), .q(bn[0])
  );

  for (genvar i = 0; i < N_E1; i++) begin : g_int
    logic [63:0] mm;
    logic [63:0] yp;

    mirs_mul u_mul (.clk(clk), .en(en), .a(yv[i]), .b(E1), .q(mm));
    mirs_dly #(.W(70), .D(L_MUL)) u_pass (
      .clk(clk), .en(en), .d({yv[i], bn[i]}), .q({yp, bn[i+1]})
    );

    assign yv[i+1] = (5'(i) < bn[i+1][4:0]) ? mm : yp;
  end

  assign y = bn[N_E1][5] ? '0 : yv[N_E1];

endmodule

[rtl/core/mu_i_rheology_stress.sv]
// ----------------------------------------------------------------------
// mu_i_rheology_stress
// Papanastasiou-regularised mu(I) viscous stress at one integration point.
// ----------------------------------------------------------------------
// One word in and one word out per cycle once full, unless the output stalls;
// latency from input to output is set by the longest dependency chain: the
// strain-rate root, the g/c divide, the exp(-g/c) series and its integer
// multiplies, the divide by g and the final two multiplies. A stall on the
// output freezes the whole pipe, so input ready is low exactly while it stalls.
// Configuration writes are taken every cycle and should only be made with
// the pipe empty.
// ----------------------------------------------------------------------
module mu_i_rheology_stress (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mirs_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mirs_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mirs_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_data
);
  import mirs_pkg::*;

  localparam int T_SQ    = L_MUL;
  localparam int T_G     = T_SQ + 1 + L_SQRT;
  localparam int T_P     = L_MUL + 1;
  localparam int T_I0    = T_P + L_DIV + L_SQRT + L_MUL;
  localparam int T_GD    = T_G + L_MUL;
  localparam int T_SEC   = T_I0 + L_DIV;
  localparam int T_EXP   = T_G + L_DIV + L_EXP;
  localparam int T_NUM   = T_EXP + L_MUL;
  localparam int T_FIRST = T_NUM + L_DIV;
  localparam int T_MU    = T_FIRST + L_MUL;
  localparam int T_DEV   = L_SDIV;
  localparam int LAT     = T_MU + L_MUL + 1;

  logic [62:0] mu_s, mu_d, i0, dia, rho, creg;
  logic [32:0] theta;
  logic        en;
  logic [LAT-1:0] vld;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mu_s  <= '0;
      mu_d  <= '0;
      i0    <= '0;
      dia   <= 63'(Q_ONE);
      rho   <= 63'(Q_ONE);
      creg  <= 63'(Q_ONE);
      theta <= 33'(Q_ONE);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MU_S:  mu_s  <= cfg_data[62:0];
        CFG_MU_D:  mu_d  <= cfg_data[62:0];
        CFG_I0:    i0    <= cfg_data[62:0];
        CFG_DIA:   dia   <= cfg_data[62:0];
        CFG_RHO:   rho   <= cfg_data[62:0];
        CFG_REG:   creg  <= cfg_data[62:0];
        CFG_THETA: theta <= cfg_data[32:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // pipe control
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  // equivalent strain rate
  logic [5:0][63:0] sv;
  logic [5:0][63:0] sq;
  logic [5:0][63:0] w;
  logic [2:0][63:0] ap, apd;
  logic [63:0]      acc, g;

  assign sv = {in_data.strain_xz, in_data.strain_yz, in_data.strain_xy,
               in_data.strain_zz, in_data.strain_yy, in_data.strain_xx};

  for (genvar i = 0; i < 6; i++) begin : g_sq
    mirs_mul u_sq (.clk(clk), .en(en), .a(f_mag(sv[i])), .b(f_mag(sv[i])), .q(sq[i]));
    if (i >= 3) begin : g_shear
      assign w[i] = f_addu(f_addu(sq[i], sq[i]), f_addu(sq[i], sq[i]));
    end else begin : g_norm
      assign w[i] = f_addu(sq[i], sq[i]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pair
    assign ap[i] = f_addu(w[2*i], w[2*i+1]);
  end

  mirs_dly #(.W(192), .D(1)) u_acc (.clk(clk), .en(en), .d(ap), .q(apd));
  assign acc = f_addu(f_addu(apd[0], apd[1]), apd[2]);

  mirs_sqrt u_gsq (.clk(clk), .en(en), .x(acc), .q(g));

  // blended, clamped pressure
  logic [32:0] th, omt;
  logic [63:0] pm0, pm1, psum, pcl, pab, pabs;
  logic [1:0]  psg;

  assign th  = (theta > 33'(Q_ONE)) ? 33'(Q_ONE) : theta;
  assign omt = 33'(Q_ONE) - th;

  mirs_mul u_po (.clk(clk), .en(en), .a(f_mag(in_data.pressure_old)),
                 .b({31'd0, omt}), .q(pm0));
  mirs_mul u_pn (.clk(clk), .en(en), .a(f_mag(in_data.pressure_new)),
                 .b({31'd0, th}), .q(pm1));
  mirs_dly #(.W(2), .D(L_MUL)) u_psg (
    .clk(clk), .en(en),
    .d({in_data.pressure_old[63], in_data.pressure_new[63]}), .q(psg)
  );

  assign psum = f_adds(f_tosig(pm0, psg[1]), f_tosig(pm1, psg[0]));
  assign pcl  = ($signed(psum) > $signed(P_TOL)) ? P_TOL : psum;
  assign pab  = ~pcl + 64'd1;

  mirs_dly #(.W(64), .D(1)) u_pab (.clk(clk), .en(en), .d(pab), .q(pabs));

  // rate-dependent friction term
  logic        dneg;
  logic [63:0] dmag, dmd, pr, prt, i0s, gd, gdd, den, secq, second;

  assign dneg = mu_d < mu_s;
  assign dmag = dneg ? 64'(mu_s - mu_d) : 64'(mu_d - mu_s);

  mirs_mul u_dmd (.clk(clk), .en(en), .a(dmag), .b({1'b0, dia}), .q(dmd));
  mirs_div u_prho (.clk(clk), .en(en), .a(pabs), .b({1'b0, rho}), .q(pr));
  mirs_sqrt u_prt (.clk(clk), .en(en), .x(pr), .q(prt));
  mirs_mul u_i0s (.clk(clk), .en(en), .a({1'b0, i0}), .b(prt), .q(i0s));
  mirs_mul u_gd (.clk(clk), .en(en), .a(g), .b({1'b0, dia}), .q(gd));
  mirs_dly #(.W(64), .D(T_I0 - T_GD)) u_gdd (.clk(clk), .en(en), .d(gd), .q(gdd));

  assign den = f_addu(i0s, gdd);

  mirs_div u_sec (.clk(clk), .en(en), .a(dmd), .b(den), .q(secq));
  assign second = f_tosig(secq, dneg);

  // regularised static term
  logic [63:0] gc, ex, omx, num, gdn, fq, first, secd, sum, pabsd, mum, mu, m2;
  logic        negd, gz, gzd;

  mirs_div u_gc (.clk(clk), .en(en), .a(g), .b({1'b0, creg}), .q(gc));
  mirs_exp u_exp (.clk(clk), .en(en), .e(gc), .y(ex));
  assign omx = Q_ONE - ex;
  mirs_mul u_num (.clk(clk), .en(en), .a({1'b0, mu_s}), .b(omx), .q(num));
  mirs_dly #(.W(64), .D(T_NUM - T_G)) u_gdn (.clk(clk), .en(en), .d(g), .q(gdn));
  mirs_div u_first (.clk(clk), .en(en), .a(num), .b(gdn), .q(fq));
  assign first = f_tosig(fq, 1'b0);

  mirs_dly #(.W(64), .D(T_FIRST - T_SEC)) u_secd (
    .clk(clk), .en(en), .d(second), .q(secd)
  );
  mirs_dly #(.W(64), .D(T_FIRST - T_P)) u_pabsd (
    .clk(clk), .en(en), .d(pabs), .q(pabsd)
  );

  assign sum = f_adds(first, secd);

  mirs_mul u_mu (.clk(clk), .en(en), .a(sum), .b(pabsd), .q(mum));
  mirs_dly #(.W(1), .D(L_MUL)) u_neg (.clk(clk), .en(en), .d(sum[63]), .q(negd));

  assign gz = (g == '0);
  mirs_dly #(.W(1), .D(T_MU - T_G)) u_gz (.clk(clk), .en(en), .d(gz), .q(gzd));

  always_comb begin
    if (gzd) mu = Q_ONE;
    else if (negd) mu = '0;
    else mu = mum[63] ? SMAX : mum;
  end

  assign m2 = mu + mu;

  // deviatoric rate
  logic [63:0]      tr, tq, tr3;
  logic             trs;
  logic [5:0][63:0] svd, dev, devd, sm;
  logic [5:0]       dsg;
  logic [62:0]      mud;
  out_t             res;

  assign tr = f_adds(f_adds(in_data.strain_xx, in_data.strain_yy), in_data.strain_zz);

  mirs_sdiv u_tr3 (.clk(clk), .en(en), .x(f_mag(tr)), .d(5'd3), .q(tq));
  mirs_dly #(.W(385), .D(L_SDIV)) u_svd (
    .clk(clk), .en(en), .d({tr[63], sv}), .q({trs, svd})
  );

  assign tr3 = f_tosig(tq, trs);

  for (genvar i = 0; i < 6; i++) begin : g_dev
    if (i < 3) begin : g_norm
      assign dev[i] = f_subs(svd[i], tr3);
    end else begin : g_shear
      assign dev[i] = svd[i];
    end
  end

  mirs_dly #(.W(384), .D(T_MU - T_DEV)) u_devd (.clk(clk), .en(en), .d(dev), .q(devd));

  for (genvar i = 0; i < 6; i++) begin : g_st
    mirs_mul u_st (.clk(clk), .en(en), .a(m2), .b(f_mag(devd[i])), .q(sm[i]));
  end

  mirs_dly #(.W(69), .D(L_MUL)) u_sgd (
    .clk(clk), .en(en),
    .d({devd[5][63], devd[4][63], devd[3][63], devd[2][63], devd[1][63], devd[0][63],
        mu[62:0]}),
    .q({dsg, mud})
  );

  assign res.stress_xx = f_tosig(sm[0], dsg[0]);
  assign res.stress_yy = f_tosig(sm[1], dsg[1]);
  assign res.stress_zz = f_tosig(sm[2], dsg[2]);
  assign res.stress_xy = f_tosig(sm[3], dsg[3]);
  assign res.stress_yz = f_tosig(sm[4], dsg[4]);
  assign res.stress_xz = f_tosig(sm[5], dsg[5]);
  assign res.viscosity = mud;

  mirs_dly #(.W($bits(out_t)), .D(1)) u_out (.clk(clk), .en(en), .d(res), .q(out_data));

endmodule

[rtl/core/mirs_chk.sv]
// ----------------------------------------------------------------------
// mirs_chk
// Port-level checks for the mu(I) stress block, bound to the top level.
// ----------------------------------------------------------------------
module mirs_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input mirs_pkg::in_t      in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mirs_pkg::out_t     out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input mirs_pkg::cfg_idx_t cfg_index,
  input logic [63:0]        cfg_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // pipe is empty straight after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // input side stalls exactly when the output side does
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

endmodule

bind mu_i_rheology_stress mirs_chk u_mirs_chk (.*);

[verif/stress_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// stress_checker
// Watches the point, result and register channels of the mu(I) stress
// block, works out the expected stress and viscosity of every accepted
// point in Q32.32 and compares each result word with the oldest one due.
// ----------------------------------------------------------------------
module stress_checker
  import mirs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_t      in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_t     out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  logic [63:0] cfg_data,
  output int       errors,
  output int       pending
);

  logic [62:0] mu_s, mu_d, i_zero, dia, rho, reg_c;
  logic [32:0] theta;
  out_t        stress_due[$];

  function automatic logic [63:0] magn(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] signed_sat(logic [63:0] m, logic neg);
    if (!neg) return (m > SMAX) ? SMAX : m;
    return (m >= SMIN) ? SMIN : -m;
  endfunction

  function automatic logic [63:0] uadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, SMAX})) return SMAX;
    if (s < $signed({1'b1, SMIN})) return SMIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) - $signed({b[63], b});
    if (s > $signed({1'b0, SMAX})) return SMAX;
    if (s < $signed({1'b1, SMIN})) return SMIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:96] != 0) ? '1 : p[95:32];
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    if (b == 0) return '1;
    q = {32'd0, a, 32'd0} / {64'd0, b};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [63:0] qroot(logic [63:0] x);
    logic [127:0] n, t;
    logic [47:0]  r;
    n = {32'd0, x, 32'd0};
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = {80'd0, r | (48'd1 << b)};
      if (t * t <= n) r = t[47:0];
    end
    return {16'd0, r};
  endfunction

  function automatic logic [63:0] exp_up(logic [63:0] f);
    logic [63:0] sum, term;
    sum  = Q_ONE;
    term = Q_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = qmul(term, f) / k;
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] exp_down(logic [63:0] e);
    logic [63:0] y, e1;
    if (e[63:32] >= 32) return '0;
    y  = qdiv(Q_ONE, exp_up({32'd0, e[31:0]}));
    e1 = qdiv(Q_ONE, exp_up(Q_ONE));
    for (int i = 0; i < e[63:32]; i++) y = qmul(y, e1);
    return y;
  endfunction

  function automatic out_t stress_of(in_t x);
    logic [63:0] s[6];
    logic [63:0] acc, g, th, p, pabs, mu, m2, tr, tr3, dev, sq, w;
    logic [63:0] dmag, den, second, first, sum;
    logic        dneg;
    out_t        r;
    s = '{x.strain_xx, x.strain_yy, x.strain_zz, x.strain_xy, x.strain_yz, x.strain_xz};
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      sq = qmul(magn(s[i]), magn(s[i]));
      w = uadd(sq, sq);
      if (i >= 3) w = uadd(w, w);
      acc = uadd(acc, w);
    end
    g = qroot(acc);
    th = (theta > Q_ONE[32:0]) ? Q_ONE : {31'd0, theta};
    p = sadd(signed_sat(qmul(magn(x.pressure_old), Q_ONE - th), x.pressure_old[63]),
             signed_sat(qmul(magn(x.pressure_new), th), x.pressure_new[63]));
    if ($signed(p) > $signed(P_TOL)) p = P_TOL;
    pabs = -p;
    if (g != 0) begin
      dneg = mu_d < mu_s;
      dmag = dneg ? {1'b0, mu_s - mu_d} : {1'b0, mu_d - mu_s};
      den = uadd(qmul({1'b0, i_zero}, qroot(qdiv(pabs, {1'b0, rho}))),
                 qmul(g, {1'b0, dia}));
      second = signed_sat(qdiv(qmul(dmag, {1'b0, dia}), den), dneg);
      first = signed_sat(qdiv(qmul({1'b0, mu_s},
                                   Q_ONE - exp_down(qdiv(g, {1'b0, reg_c}))), g), 1'b0);
      sum = sadd(first, second);
      if (sum[63]) mu = '0;
      else begin
        mu = qmul(sum, pabs);
        if (mu > SMAX) mu = SMAX;
      end
    end else mu = Q_ONE;
    m2 = mu + mu;
    tr = sadd(sadd(s[0], s[1]), s[2]);
    tr3 = signed_sat(magn(tr) / 3, tr[63]);
    for (int i = 0; i < 6; i++) begin
      dev = (i < 3) ? ssub(s[i], tr3) : s[i];
      s[i] = signed_sat(qmul(m2, magn(dev)), dev[63]);
    end
    r.stress_xx = s[0];
    r.stress_yy = s[1];
    r.stress_zz = s[2];
    r.stress_xy = s[3];
    r.stress_yz = s[4];
    r.stress_xz = s[5];
    r.viscosity = mu[62:0];
    return r;
  endfunction

  function automatic int field_bad(string name, logic [63:0] e, logic [63:0] a);
    if (e === a) return 0;
    $error("%s: expected %h, got %h", name, e, a);
    return 1;
  endfunction

  assign pending = stress_due.size();

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      mu_s   <= '0;
      mu_d   <= '0;
      i_zero <= '0;
      dia    <= Q_ONE[62:0];
      rho    <= Q_ONE[62:0];
      reg_c  <= Q_ONE[62:0];
      theta  <= Q_ONE[32:0];
      errors <= 0;
      stress_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MU_S:  mu_s   <= cfg_data[62:0];
          CFG_MU_D:  mu_d   <= cfg_data[62:0];
          CFG_I0:    i_zero <= cfg_data[62:0];
          CFG_DIA:   dia    <= cfg_data[62:0];
          CFG_RHO:   rho    <= cfg_data[62:0];
          CFG_REG:   reg_c  <= cfg_data[62:0];
          CFG_THETA: theta  <= cfg_data[32:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) stress_due.push_back(stress_of(in_data));
      if (out_valid && out_ready) begin
        if (stress_due.size() == 0) begin
          $error("result word with nothing due");
          errors <= errors + 1;
        end else begin
          e = stress_due.pop_front();
          errors <= errors
            + field_bad("stress_xx", e.stress_xx, out_data.stress_xx)
            + field_bad("stress_yy", e.stress_yy, out_data.stress_yy)
            + field_bad("stress_zz", e.stress_zz, out_data.stress_zz)
            + field_bad("stress_xy", e.stress_xy, out_data.stress_xy)
            + field_bad("stress_yz", e.stress_yz, out_data.stress_yz)
            + field_bad("stress_xz", e.stress_xz, out_data.stress_xz)
            + field_bad("viscosity", {1'b0, e.viscosity}, {1'b0, out_data.viscosity});
        end
      end
    end
  end

endmodule

[verif/tb_mu_i_rheology_stress.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// tb_mu_i_rheology_stress
// Drives integration points and register sets into the mu(I) stress
// block: a directed set of extremes, then random points under several
// friction, grain and theta settings, with random gaps and back-pressure.
// ----------------------------------------------------------------------
module tb_mu_i_rheology_stress;
  import mirs_pkg::*;

  localparam int LATENCY = 608;
  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_t      in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_t     out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int       errors;
  int       pending;
  bit       steady_sink = 1'b0;

  always #4 clk = ~clk;

  mu_i_rheology_stress dut (.*);

  stress_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] any_word();
    case ($urandom_range(0, 7))
      0, 1:    return {$urandom, $urandom};
      2:       return 64'($signed($urandom_range(0, 32'hFFFF_FFFF))) <<< $urandom_range(0, 6);
      3:       return -(64'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 6));
      4:       return '0;
      5:       return $urandom_range(0, 1) ? SMAX : SMIN;
      default: return 64'($signed($urandom_range(0, 2000))) - 64'd1000;
    endcase
  endfunction

  function automatic logic [63:0] friction_word();
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom} & MAX63;
      1:       return '0;
      default: return 64'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 3);
    endcase
  endfunction

  function automatic in_t random_point();
    in_t x;
    x.strain_xx = any_word();
    x.strain_yy = any_word();
    x.strain_zz = any_word();
    x.strain_xy = any_word();
    x.strain_yz = any_word();
    x.strain_xz = any_word();
    if ($urandom_range(0, 9) == 0) begin
      x.strain_xx = '0; x.strain_yy = '0; x.strain_zz = '0;
      x.strain_xy = '0; x.strain_yz = '0; x.strain_xz = '0;
    end
    if ($urandom_range(0, 3) == 0) begin
      x.pressure_old = any_word();
      x.pressure_new = any_word();
    end else begin
      x.pressure_old = -(64'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 8));
      x.pressure_new = -(64'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 8));
    end
    return x;
  endfunction

  task automatic send_point(input in_t x);
    int g;
    in_valid <= 1'b1;
    in_data  <= x;
    @(negedge clk);
    while (!in_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic load_set(input logic [63:0] ms, md, i0, d, rh, c, th);
    write_reg(CFG_MU_S, ms);
    write_reg(CFG_MU_D, md);
    write_reg(CFG_I0, i0);
    write_reg(CFG_DIA, d);
    write_reg(CFG_RHO, rh);
    write_reg(CFG_REG, c);
    write_reg(CFG_THETA, th);
    cfg_valid <= 1'b0;
  endtask

  // result-side back-pressure
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (steady_sink) out_ready <= 1'b1;
      else begin
        hold = gap_len();
        if (hold == 0) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          repeat (hold - 1) @(posedge clk);
          @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("mu_i_rheology_stress test failed");
    $finish;
  end

  initial begin
    in_t x;
    logic [63:0] q;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points under a fixed register set
    load_set(64'h0000_0000_6666_6666, 64'h0000_0000_A000_0000, 64'h0000_0000_1999_9999,
             Q_ONE, Q_ONE, Q_ONE, 64'h0000_0000_8000_0000);
    for (int i = 0; i < 22; i++) begin
      q = (i % 2) ? SMAX : SMIN;
      x = '0;
      case (i)
        0: ;
        1: x.pressure_new = SMIN;
        2: x.pressure_new = SMAX;
        3: begin x.strain_xx = Q_ONE; x.pressure_new = -Q_ONE; end
        4: begin x.strain_xy = SMAX; x.pressure_old = SMIN; x.pressure_new = SMIN; end
        5: begin x.strain_xx = SMIN; x.strain_yy = SMIN; x.strain_zz = SMIN; end
        6: begin x.strain_xx = SMAX; x.strain_yy = SMAX; x.strain_zz = SMAX;
                 x.pressure_new = -64'd1; end
        7: begin x.strain_yz = 64'd1; x.pressure_new = 64'hFFFF_FFFF_FFFF_FE52; end
        8: begin x.strain_xz = -Q_ONE; x.pressure_old = -(Q_ONE << 4); end
        9: begin x.strain_xx = Q_ONE <<< 40; x.strain_yy = -(Q_ONE <<< 40); end
        default: begin
          x = random_point();
          x.strain_xx = q;
          x.pressure_old = q;
        end
      endcase
      send_point(x);
    end
    drain();

    // settings: reset-like, extremes, zero divisors, theta above one, a mid-range set, random
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: load_set(0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        1: load_set(MAX63, MAX63, MAX63, MAX63, MAX63, MAX63, 64'h1_FFFF_FFFF);
        2: load_set(0, 0, 0, 0, 0, 0, 0);
        3: load_set(64'h0000_0000_9999_9999, 64'h0000_0000_4CCC_CCCC, Q_ONE,
                    64'h0000_0000_0100_0000, Q_ONE << 10, 0, 64'h1_0000_0001);
        4: load_set(64'h0000_0000_6666_6666, 64'h0000_0000_B333_3333,
                    64'h0000_0000_0500_0000, 64'h0000_0000_0010_0000, Q_ONE << 11,
                    64'h0000_0000_0000_1000, 64'h0000_0000_8000_0000);
        default: load_set(friction_word(), friction_word(), friction_word(),
                          friction_word(), friction_word(), friction_word(),
                          {31'd0, 1'b0, $urandom} | ($urandom_range(0, 3) == 0 ?
                           64'h1_0000_0000 : 64'h0));
      endcase
      steady_sink = (ph == 6);
      for (int i = 0; i < 136; i++) begin
        send_point(random_point());
        if (i == 60 && ph == 5) drain();
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("mu_i_rheology_stress test passed");
    else $display("mu_i_rheology_stress test failed");
    $finish;
  end

endmodule

[mu_i_rheology_stress.f]
rtl/core/mirs_pkg.sv
rtl/core/mirs_dly.sv
rtl/core/mirs_mul.sv
rtl/core/mirs_sdiv.sv
rtl/core/mirs_div.sv
rtl/core/mirs_sqrt.sv
rtl/core/mirs_exp.sv
rtl/core/mu_i_rheology_stress.sv
rtl/core/mirs_chk.sv
verif/stress_checker.sv
verif/tb_mu_i_rheology_stress.sv
